[sv/glyph_atlas_shelf_cache_macros.svh]
// ----------------------------------------------------------------------------
// Glyph atlas shelf cache assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ATLAS_SHELF_CACHE_MACROS_SVH
`define GLYPH_ATLAS_SHELF_CACHE_MACROS_SVH

// same-cycle implication, disabled during reset
`define GASC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glyph atlas check failed");

// next-cycle implication, disabled during reset
`define GASC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glyph atlas check failed");

// implication that is also checked across reset
`define GASC_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("glyph atlas check failed");

`endif

[sv/gasc_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph atlas shelf cache package
// Shared types, result codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gasc_pkg;

  // result codes
  typedef enum logic [1:0] {
    ST_HIT        = 2'd0,
    ST_PLACED     = 2'd1,
    ST_ATLAS_FULL = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [1:0] REG_ATLAS_WIDTH = 2'd0;
  localparam logic [1:0] REG_START_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_HEIGHT = 2'd2;

  localparam logic [12:0] RESET_ATLAS_WIDTH = 13'd1024;
  localparam logic [14:0] RESET_START_HEIGHT = 15'd1024;
  localparam logic [14:0] RESET_MAX_HEIGHT = 15'd8192;

  localparam logic [12:0] SAT_X = 13'h1fff;
  localparam logic [14:0] SAT_Y = 15'h7fff;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WRAP,
    S_PLACE,
    S_EMIT
  } state_t;

  // one stored glyph
  typedef struct packed {
    logic [20:0] char_code;
    logic [11:0] x;
    logic [13:0] y;
    logic [7:0]  w;
    logic [7:0]  h;
  } entry_t;

  typedef struct packed {
    logic        en;
    logic [1:0]  idx;
    logic [14:0] data;
  } cfg_wr_t;

  // sequencer to shelf allocator
  typedef struct packed {
    logic wrap;
    logic place;
  } shelf_ctl_t;

  // shelf allocator to sequencer
  typedef struct packed {
    logic [11:0] x;
    logic [13:0] y;
    logic        full;
  } shelf_pos_t;

endpackage

`default_nettype wire

[sv/gasc_table.sv]
// ----------------------------------------------------------------------------
// Glyph table memory
// Single-port-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gasc_table #(
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire gasc_pkg::entry_t         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output gasc_pkg::entry_t              rdata
);
  import gasc_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/gasc_shelf.sv]
// ----------------------------------------------------------------------------
// Shelf allocator
// Holds the configuration, the current shelf, the next-row mark and the atlas
// height, and places one glyph per place step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gasc_shelf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire gasc_pkg::cfg_wr_t    cfg,
  input  wire gasc_pkg::shelf_ctl_t ctl,
  input  wire logic [7:0]           glyph_w,
  input  wire logic [7:0]           glyph_h,
  output gasc_pkg::shelf_pos_t      pos
);
  import gasc_pkg::*;

  logic [12:0] atlas_width;
  logic [14:0] max_height;
  logic [14:0] atlas_height;
  logic [12:0] shelf_x;
  logic [14:0] shelf_y;
  logic [14:0] next_row;

  logic [13:0] sum_x;
  logic [15:0] sum_y;
  logic [15:0] row_end;
  logic        wrap_needed;
  logic        grow_needed;
  logic [14:0] height_doubled;

  assign sum_x = {1'b0, shelf_x} + 14'(glyph_w) + 14'd1;
  assign sum_y = {1'b0, shelf_y} + 16'(glyph_h);
  assign row_end = sum_y + 16'd1;
  assign wrap_needed = sum_x >= {1'b0, atlas_width};
  assign grow_needed = sum_y >= {1'b0, atlas_height};
  // doubling past 15 bits saturates
  assign height_doubled = atlas_height[14] ? SAT_Y : {atlas_height[13:0], 1'b0};

  assign pos.x = shelf_x[11:0];
  assign pos.y = shelf_y[13:0];
  assign pos.full = grow_needed && (atlas_height >= max_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width <= RESET_ATLAS_WIDTH;
      max_height <= RESET_MAX_HEIGHT;
      atlas_height <= RESET_START_HEIGHT;
      shelf_x <= '0;
      shelf_y <= '0;
      next_row <= '0;
    end else begin
      if (cfg.en) begin
        unique case (cfg.idx)
          REG_ATLAS_WIDTH: atlas_width <= cfg.data[12:0];
          REG_START_HEIGHT: atlas_height <= cfg.data;
          REG_MAX_HEIGHT: max_height <= cfg.data;
          default: ;
        endcase
      end
      if (ctl.wrap && wrap_needed) begin
        shelf_x <= '0;
        shelf_y <= next_row;
      end
      if (ctl.place && !pos.full) begin
        if (grow_needed) begin
          atlas_height <= height_doubled;
        end
        if (row_end > {1'b0, next_row}) begin
          next_row <= row_end[15] ? SAT_Y : row_end[14:0];
        end
        shelf_x <= sum_x[13] ? SAT_X : sum_x[12:0];
      end
    end
  end

endmodule

`default_nettype wire

[sv/glyph_atlas_shelf_cache.sv]
// ----------------------------------------------------------------------------
// Glyph atlas shelf cache
// Looks glyphs up in a table of placed glyphs and packs new ones onto shelves.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    char_code, glyph_w, glyph_h
//  output    out        out_valid / out_stall  status, tex_x, tex_y, out_w, out_h
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  The walk reads one table entry per cycle from the single RAM read port, and a
//  hit ends the walk as soon as the entry read from the table matches the code.
//  No clearing pass: the table is valid up to the fill count from reset on.
//  One item is worked on at a time; a result held by out_stall does not block
//  the next input transfer, only the delivery of its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glyph_atlas_shelf_cache #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [20:0] char_code,
  input  wire logic [7:0]  glyph_w,
  input  wire logic [7:0]  glyph_h,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [11:0]      tex_x,
  output logic [13:0]      tex_y,
  output logic [7:0]       out_w,
  output logic [7:0]       out_h,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  import gasc_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  state_t state;
  state_t state_next;

  logic [CW-1:0] entry_count;
  logic [CW-1:0] ptr;
  logic          pend;
  logic [20:0]   req_code;
  logic [7:0]    req_w;
  logic [7:0]    req_h;

  status_t res_status;
  logic [11:0] res_x;
  logic [13:0] res_y;
  logic [7:0]  res_w;
  logic [7:0]  res_h;

  // combinational controls
  logic        accept;
  logic        rd_issue;
  logic        mem_we;
  logic        res_load;
  logic        out_load;
  status_t     res_status_next;
  entry_t      res_entry_next;

  entry_t      rdata;
  entry_t      wdata;
  cfg_wr_t     cfg_wr;
  shelf_ctl_t  shelf_ctl;
  shelf_pos_t  shelf_pos;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign cfg_wr.en = cfg_valid && cfg_ready;
  assign cfg_wr.idx = cfg_index;
  assign cfg_wr.data = cfg_data;

  assign wdata.char_code = req_code;
  assign wdata.x = shelf_pos.x;
  assign wdata.y = shelf_pos.y;
  assign wdata.w = req_w;
  assign wdata.h = req_h;

  gasc_table #(
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(entry_count[IW-1:0]),
    .wdata(wdata),
    .raddr(ptr[IW-1:0]),
    .rdata(rdata)
  );

  gasc_shelf u_shelf (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_wr),
    .ctl    (shelf_ctl),
    .glyph_w(req_w),
    .glyph_h(req_h),
    .pos    (shelf_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_issue = 1'b0;
    mem_we = 1'b0;
    res_load = 1'b0;
    out_load = 1'b0;
    shelf_ctl = '0;
    res_status_next = ST_HIT;
    res_entry_next = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // rdata holds the entry read in the previous cycle
        priority if (pend && rdata.char_code == req_code) begin
          res_status_next = ST_HIT;
          res_entry_next = rdata;
          res_load = 1'b1;
          state_next = S_EMIT;
        end else if (ptr != entry_count) begin
          rd_issue = 1'b1;
        end else if (entry_count == FULL_COUNT) begin
          res_status_next = ST_TABLE_FULL;
          res_load = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_WRAP;
        end
      end
      S_WRAP: begin
        shelf_ctl.wrap = 1'b1;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        shelf_ctl.place = 1'b1;
        res_load = 1'b1;
        if (shelf_pos.full) begin
          res_status_next = ST_ATLAS_FULL;
        end else begin
          mem_we = 1'b1;
          res_status_next = ST_PLACED;
          res_entry_next = wdata;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      out_valid <= 1'b0;
      ptr <= '0;
      pend <= 1'b0;
    end else begin
      if (accept) begin
        ptr <= '0;
        pend <= 1'b0;
      end else if (state == S_SEARCH) begin
        pend <= rd_issue;
        if (rd_issue) begin
          ptr <= ptr + CW'(1);
        end
      end
      if (mem_we) begin
        entry_count <= entry_count + CW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_code <= char_code;
      req_w <= glyph_w;
      req_h <= glyph_h;
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_x <= res_entry_next.x;
      res_y <= res_entry_next.y;
      res_w <= res_entry_next.w;
      res_h <= res_entry_next.h;
    end
    if (out_load) begin
      status <= res_status;
      tex_x <= res_x;
      tex_y <= res_y;
      out_w <= res_w;
      out_h <= res_h;
    end
  end

endmodule

`default_nettype wire

[sv/gasc_checker.sv]
// ----------------------------------------------------------------------------
// Glyph atlas shelf cache port checker
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "glyph_atlas_shelf_cache_macros.svh"

module gasc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [11:0] tex_x,
  input wire logic [13:0] tex_y,
  input wire logic [7:0]  out_w,
  input wire logic [7:0]  out_h
);
  import gasc_pkg::*;

  // failed requests carry an all-zero position and size
  `GASC_ASSERT_NOW(a_fail_zero, clk, rst,
    out_valid && (status == ST_ATLAS_FULL || status == ST_TABLE_FULL),
    tex_x == '0 && tex_y == '0 && out_w == '0 && out_h == '0)

  // one item at a time: a transfer closes the input until its work is done
  `GASC_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && !in_stall, in_stall)

  // a held result stays on offer
  `GASC_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && out_stall, out_valid)

  // nothing is offered straight out of reset
  `GASC_ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst) && !rst, !out_valid && !in_stall)

endmodule

bind glyph_atlas_shelf_cache gasc_checker u_gasc_checker (.*);

`default_nettype wire
